// File: rtl/xoshiro256ss_random_generator_macros.svh
// Assertion helpers for the generator; clock and reset are the top level's.
`ifndef XOSHIRO256SS_RANDOM_GENERATOR_MACROS_SVH
`define XOSHIRO256SS_RANDOM_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle.
`define XSR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xsr assertion failed");

// Consequent must hold in the next cycle.
`define XSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xsr assertion failed");

`endif

// File: rtl/xsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package xsr_pkg;

	localparam int UADDR_W = 4;

	localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

	localparam logic [1:0] REQ_RESEED  = 2'd0;
	localparam logic [1:0] REQ_RAW     = 2'd1;
	localparam logic [1:0] REQ_BOUNDED = 2'd2;

	// datapath operation of one step
	typedef enum logic [3:0] {
		OP_NONE,
		OP_SEED_ADD,   // acc += gamma, z = acc ^ (acc >> 30)
		OP_MUL_LL,     // p = z_lo * c_lo
		OP_MUL_HL,     // p += (z_hi * c_lo) << 32
		OP_MUL_LHZ,    // z = p + (z_lo * c_hi) << 32
		OP_XS27,       // z ^= z >> 27
		OP_MIX_FIN,    // word[k] = z ^ (z >> 31), k++
		OP_DRAW_ROT,   // z = rotl(w1 * 5, 7), advance state
		OP_TIMES9,     // z = z * 9
		OP_BND_LO,     // p = frac_lo * bound
		OP_BND_HI      // result from (p >> 32) + frac_hi * bound
	} op_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_DONE,
		SEQ_LOOP,      // jump to target until the last word is written
		SEQ_RAW        // done for a raw draw, else fall through
	} seq_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_T9,
		RES_BND
	} res_t;

	typedef struct packed {
		op_t                  op;
		logic                 csel;    // 0: MIX_MUL_A, 1: MIX_MUL_B
		seq_t                 seq;
		res_t                 res;
		logic [UADDR_W-1:0]   target;
	} ucode_t;

	localparam logic [UADDR_W-1:0] ENTRY_RESEED = 4'd0;
	localparam logic [UADDR_W-1:0] ENTRY_DRAW   = 4'd9;
	localparam logic [UADDR_W-1:0] ENTRY_NOP    = 4'd13;

	function automatic ucode_t ucode_rom(input logic [UADDR_W-1:0] addr);
		ucode_t cw;
		cw = '{op: OP_NONE, csel: 1'b0, seq: SEQ_DONE, res: RES_ZERO, target: '0};
		unique case (addr)
			4'd0:  cw = '{OP_SEED_ADD, 1'b0, SEQ_NEXT, RES_ZERO, 4'd0};
			4'd1:  cw = '{OP_MUL_LL,   1'b0, SEQ_NEXT, RES_ZERO, 4'd0};
			4'd2:  cw = '{OP_MUL_HL,   1'b0, SEQ_NEXT, RES_ZERO, 4'd0};
			4'd3:  cw = '{OP_MUL_LHZ,  1'b0, SEQ_NEXT, RES_ZERO, 4'd0};
			4'd4:  cw = '{OP_XS27,     1'b0, SEQ_NEXT, RES_ZERO, 4'd0};
			4'd5:  cw = '{OP_MUL_LL,   1'b1, SEQ_NEXT, RES_ZERO, 4'd0};
			4'd6:  cw = '{OP_MUL_HL,   1'b1, SEQ_NEXT, RES_ZERO, 4'd0};
			4'd7:  cw = '{OP_MUL_LHZ,  1'b1, SEQ_NEXT, RES_ZERO, 4'd0};
			4'd8:  cw = '{OP_MIX_FIN,  1'b0, SEQ_LOOP, RES_ZERO, ENTRY_RESEED};
			4'd9:  cw = '{OP_DRAW_ROT, 1'b0, SEQ_NEXT, RES_ZERO, 4'd0};
			4'd10: cw = '{OP_TIMES9,   1'b0, SEQ_RAW,  RES_T9,   4'd0};
			4'd11: cw = '{OP_BND_LO,   1'b0, SEQ_NEXT, RES_ZERO, 4'd0};
			4'd12: cw = '{OP_BND_HI,   1'b0, SEQ_DONE, RES_BND,  4'd0};
			default: cw = '{OP_NONE,   1'b0, SEQ_DONE, RES_ZERO, 4'd0};
		endcase
		return cw;
	endfunction

endpackage
`default_nettype wire

// File: rtl/xoshiro256ss_random_generator.sv
// channel | signals                              | direction
// in      | in_valid, in_ready, req_type, bound  | request item into block
// out     | out_valid, out_ready, value          | result item out of block
// cfg     | cfg_valid, cfg_ready, cfg_data       | seed register write
// A microcode ROM steps one control word per cycle over one shared 32x32 multiplier.
// Program length in steps: raw draw 2, bounded draw 4, unused code 1, reseed 36
// (4 SplitMix64 rounds of 9 steps, two 64-bit multiplies of 3 steps each).
// in_ready is high when no program runs, so items arrive in the cycle after the last step.
// The finished item waits in the output register while the next program runs; that
// program stalls on its final step while the register is full. Reset zeroes state and seed.
`timescale 1ns / 1ps
`default_nettype none
`include "xoshiro256ss_random_generator_macros.svh"
module xoshiro256ss_random_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [30:0] bound,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      value
);
	import xsr_pkg::*;

	logic [63:0]        w_q [4];
	logic [63:0]        seed_q;
	logic [63:0]        acc_q;
	logic [63:0]        z_q;
	logic [63:0]        p_q;
	logic [30:0]        bound_q;
	logic [1:0]         req_q;
	logic [1:0]         k_q;
	logic [UADDR_W-1:0] pc_q;
	logic               busy_q;
	logic               out_valid_q;
	logic [63:0]        value_q;

	ucode_t             cw;
	logic               is_done;
	logic               adv;
	logic               in_acc;
	logic [UADDR_W-1:0] entry;
	logic [63:0]        cst;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        prod;
	logic [63:0]        acc_nxt;
	logic [63:0]        t9;
	logic [63:0]        w1x5;
	logic [63:0]        n0, n1, n2, n3;
	logic [63:0]        mid;
	logic [63:0]        res_val;

	assign cw        = ucode_rom(pc_q);
	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign value     = value_q;

	always_comb begin
		unique case (cw.seq)
			SEQ_NEXT: is_done = 1'b0;
			SEQ_DONE: is_done = 1'b1;
			SEQ_LOOP: is_done = (k_q == 2'd3);
			SEQ_RAW:  is_done = (req_q == REQ_RAW);
			default:  is_done = 1'b1;
		endcase
	end

	// a final step waits while the previous item still sits in the output register
	assign adv = busy_q && !(is_done && out_valid_q && !out_ready);

	always_comb begin
		unique case (req_type)
			REQ_RESEED:  entry = ENTRY_RESEED;
			REQ_RAW:     entry = ENTRY_DRAW;
			REQ_BOUNDED: entry = ENTRY_DRAW;
			default:     entry = ENTRY_NOP;
		endcase
	end

	// shared multiplier
	assign cst = cw.csel ? MIX_MUL_B : MIX_MUL_A;
	always_comb begin
		mul_a = z_q[31:0];
		mul_b = cst[31:0];
		unique case (cw.op)
			OP_MUL_HL:  mul_a = z_q[63:32];
			OP_MUL_LHZ: mul_b = cst[63:32];
			OP_BND_LO: begin
				mul_a = z_q[42:11];
				mul_b = {1'b0, bound_q};
			end
			OP_BND_HI: begin
				mul_a = {11'b0, z_q[63:43]};
				mul_b = {1'b0, bound_q};
			end
			default: begin
				mul_a = z_q[31:0];
				mul_b = cst[31:0];
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign acc_nxt = acc_q + GOLDEN_GAMMA;
	assign t9      = z_q + {z_q[60:0], 3'b0};
	assign w1x5    = w_q[1] + {w_q[1][61:0], 2'b0};
	assign mid     = {32'b0, p_q[63:32]} + prod;

	// xoshiro256 linear step on the current words
	always_comb begin
		logic [63:0] x2;
		logic [63:0] x3;
		x2 = w_q[2] ^ w_q[0];
		x3 = w_q[3] ^ w_q[1];
		n1 = w_q[1] ^ x2;
		n0 = w_q[0] ^ x3;
		n2 = x2 ^ {w_q[1][46:0], 17'b0};
		n3 = {x3[18:0], x3[63:19]};
	end

	always_comb begin
		unique case (cw.res)
			RES_ZERO: res_val = 64'd0;
			RES_T9:   res_val = t9;
			RES_BND:  res_val = {21'b0, mid[63:21]};
			default:  res_val = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			k_q         <= '0;
			req_q       <= '0;
			out_valid_q <= 1'b0;
			seed_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				w_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_q <= cfg_data;
			end
			if (in_acc) begin
				busy_q <= 1'b1;
				pc_q   <= entry;
				req_q  <= req_type;
				k_q    <= '0;
			end else if (adv) begin
				if (is_done) begin
					busy_q <= 1'b0;
				end else if (cw.seq == SEQ_LOOP) begin
					pc_q <= cw.target;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
				if (cw.op == OP_MIX_FIN) begin
					w_q[k_q] <= z_q ^ {31'b0, z_q[63:31]};
					k_q      <= k_q + 1'b1;
				end
				if (cw.op == OP_DRAW_ROT) begin
					w_q[0] <= n0;
					w_q[1] <= n1;
					w_q[2] <= n2;
					w_q[3] <= n3;
				end
			end
			if (adv && is_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_q   <= seed_q;
			bound_q <= bound;
		end else if (adv) begin
			unique case (cw.op)
				OP_SEED_ADD: begin
					acc_q <= acc_nxt;
					z_q   <= acc_nxt ^ {30'b0, acc_nxt[63:30]};
				end
				OP_MUL_LL:   p_q <= prod;
				OP_MUL_HL:   p_q <= p_q + {prod[31:0], 32'b0};
				OP_MUL_LHZ:  z_q <= p_q + {prod[31:0], 32'b0};
				OP_XS27:     z_q <= z_q ^ {27'b0, z_q[63:27]};
				OP_DRAW_ROT: z_q <= {w1x5[56:0], w1x5[63:57]};
				OP_TIMES9:   z_q <= t9;
				OP_BND_LO:   p_q <= prod;
				default: begin
				end
			endcase
		end
		if (adv && is_done) begin
			value_q <= res_val;
		end
	end

	`XSR_ASSERT_NEXT(a_accept_busy, in_acc, busy_q && !in_ready)
	`XSR_ASSERT_NEXT(a_done_posts, adv && is_done, out_valid_q && !busy_q)
	`XSR_ASSERT_NEXT(a_bounded_below,
		adv && is_done && (cw.res == RES_BND),
		(value_q < {33'b0, bound_q}) || (bound_q == 31'd0))
	`XSR_ASSERT_NOW(a_stall_only_full, busy_q && !adv, out_valid_q && !out_ready)

endmodule
`default_nettype wire
